[rtl/bhfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-header frame decoder package
// Beat types, parse phase and status codes, and the per-bit header decode
// functions shared by the decoder modules.
// ----------------------------------------------------------------------------
package bhfd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [4:0] BIN_CODE_RESET = 5'd12;

    // Parse phases.
    localparam logic [2:0] PH_SEEK    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_META    = 3'd2;
    localparam logic [2:0] PH_BINARY  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_DISCARD = 3'd5;

    // Frame status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MARKER = 2'd1;
    localparam logic [1:0] ST_META_BAD  = 2'd2;
    localparam logic [1:0] ST_PAY_BAD   = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_META    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Header length in bits after the marker.
    localparam logic [4:0] HDR_LEN_BASE = 5'd15;
    localparam logic [4:0] HDR_LEN_VER  = 5'd23;
    localparam logic [4:0] SUBTYPE_BITS = 5'd4;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] data_out;
        logic       versioned_flag;
        logic [7:0] version_byte;
        logic [4:0] message_type;
        logic       compressed_flag;
        logic [7:0] metadata_length;
        logic [3:0] binary_subtype;
        logic [1:0] status;
        logic       run_last;
    } t_out_beat;

    typedef struct packed {
        logic       versioned;
        logic [7:0] version;
        logic [4:0] mtype;
        logic       compressed;
        logic [7:0] mdata_len;
        logic [3:0] subtype;
    } t_hdr;

    typedef struct packed {
        logic [2:0] phase;
        logic [4:0] hbc;
        t_hdr       hdr;
        logic [7:0] meta_rem;
        logic [1:0] err;
    } t_pstate;

    // Results of one byte: an optional data beat and an optional summary beat.
    typedef struct packed {
        logic      data_valid;
        t_out_beat data_beat;
        logic      sum_valid;
        t_out_beat sum_beat;
    } t_res;

    localparam t_pstate STATE_CLEAR = '{
        phase: PH_SEEK, hbc: 5'd0, hdr: '0, meta_rem: 8'd0, err: ST_OK
    };

    // Decision once the metadata is over or absent.
    function automatic t_pstate after_meta(t_pstate s, logic [4:0] code, logic aligned);
        t_pstate r;
        r = s;
        if (s.hdr.mtype == code) begin
            r.phase = PH_BINARY;
            r.hbc   = 5'd0;
        end else if (aligned) begin
            r.phase = PH_PAYLOAD;
        end else begin
            r.err   = ST_PAY_BAD;
            r.phase = PH_DISCARD;
        end
        return r;
    endfunction

    // One header bit. Phases that are not bit-wise pass through unchanged.
    function automatic t_pstate bit_step(t_pstate s, logic b, logic [4:0] code,
                                         logic aligned);
        t_pstate    r;
        logic [4:0] rel;
        logic [4:0] hlen;
        r    = s;
        rel  = 5'd0;
        hlen = 5'd0;
        case (s.phase)
            PH_SEEK: begin
                if (b) begin
                    r.phase = PH_HEADER;
                end
            end
            PH_BINARY: begin
                r.hdr.subtype = {s.hdr.subtype[2:0], b};
                r.hbc         = s.hbc + 5'd1;
                if (r.hbc == SUBTYPE_BITS) begin
                    if (aligned) begin
                        r.phase = PH_PAYLOAD;
                    end else begin
                        r.err   = ST_PAY_BAD;
                        r.phase = PH_DISCARD;
                    end
                end
            end
            PH_HEADER: begin
                if (s.hbc == 5'd0) begin
                    r.hdr.versioned = b;
                end else if (s.hdr.versioned && s.hbc <= 5'd8) begin
                    r.hdr.version = {s.hdr.version[6:0], b};
                end else begin
                    rel = s.hdr.versioned ? (s.hbc - 5'd9) : (s.hbc - 5'd1);
                    if (rel < 5'd5) begin
                        r.hdr.mtype = {s.hdr.mtype[3:0], b};
                    end else if (rel == 5'd5) begin
                        r.hdr.compressed = b;
                    end else begin
                        r.hdr.mdata_len = {s.hdr.mdata_len[6:0], b};
                    end
                end
                r.hbc = s.hbc + 5'd1;
                hlen  = r.hdr.versioned ? HDR_LEN_VER : HDR_LEN_BASE;
                if (r.hbc == hlen) begin
                    if (r.hdr.mdata_len != 8'd0) begin
                        if (aligned) begin
                            r.phase    = PH_META;
                            r.meta_rem = r.hdr.mdata_len;
                        end else begin
                            r.err   = ST_META_BAD;
                            r.phase = PH_DISCARD;
                        end
                    end else begin
                        r = after_meta(r, code, aligned);
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Status at frame end. Every phase that still decides the status ends a
    // byte on a byte boundary, so the missing bits alone set the alignment.
    function automatic t_pstate finish(t_pstate s, logic [4:0] code);
        t_pstate    r;
        logic [2:0] p;
        logic [4:0] hlen;
        r    = s;
        p    = 3'd0;
        hlen = s.hdr.versioned ? HDR_LEN_VER : HDR_LEN_BASE;
        case (s.phase)
            PH_SEEK: begin
                r.err = ST_NO_MARKER;
            end
            PH_HEADER: begin
                if (s.hbc == 5'd0) begin
                    // The marker was the very last bit of the frame.
                    r.err = ST_NO_MARKER;
                end else if (s.hdr.mdata_len != 8'd0) begin
                    r.err = ST_META_BAD;
                end else begin
                    p = hlen[2:0] - s.hbc[2:0];
                    if (s.hdr.mtype == code) begin
                        p = p + 3'd4;
                    end
                    r.err = (p != 3'd0) ? ST_PAY_BAD : ST_OK;
                end
            end
            PH_BINARY: begin
                p     = SUBTYPE_BITS[2:0] - s.hbc[2:0];
                r.err = (p != 3'd0) ? ST_PAY_BAD : ST_OK;
            end
            PH_META: begin
                r.err = ST_META_BAD;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

endpackage

[rtl/bit_header_frame_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-header frame decoder
// Decodes a marker-led bit header from a byte stream and emits metadata,
// payload and end-of-frame summary beats.
// ----------------------------------------------------------------------------
// The decoder takes one frame byte per cycle while its input is not stalled.
// A taken beat is registered, decoded once the queue has room by fixed logic
// that handles all eight header bits of the byte at once, and its results
// are registered in a small output queue. Metadata and payload bytes give
// one result each; the final byte of a frame adds a summary beat, and since
// the output hands out one beat per cycle the input stalls while a beat is
// held and the queue has fewer than two free slots. With the output never
// stalled, frames longer than one byte run at one byte per cycle.
// The binary type code register should be written only while no frame is
// in flight.
// ----------------------------------------------------------------------------
module bit_header_frame_decoder #(
    parameter int P_QUEUE_DEPTH = bhfd_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bhfd_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bhfd_pkg::t_out_beat o_out_beat,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_wdata
);
    import bhfd_pkg::*;

    logic       r_in_valid;
    t_in_beat   r_in_beat;
    logic [4:0] r_bin_code;
    logic       n_in_valid;
    logic       accept;
    logic       fire;
    logic       room2;
    t_res       res;

    assign o_in_stall = r_in_valid && !room2;
    assign accept     = i_in_valid && !o_in_stall;
    assign fire       = r_in_valid && room2;

    always_comb begin
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_bin_code <= BIN_CODE_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                r_bin_code <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_beat <= i_in_beat;
        end
    end

    bhfd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_beat     (r_in_beat),
        .i_bin_code (r_bin_code),
        .o_res      (res)
    );

    bhfd_out_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (fire && res.data_valid),
        .i_beat_a (res.data_beat),
        .i_push_b (fire && res.sum_valid),
        .i_beat_b (res.sum_beat),
        .o_room2  (room2),
        .o_valid  (o_out_valid),
        .o_beat   (o_out_beat),
        .i_stall  (i_out_stall)
    );

endmodule

[rtl/bhfd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-header frame parser
// Holds the frame parse state and decodes one byte per cycle, when fired,
// into an optional metadata or payload beat and an optional end-of-frame summary.
// ----------------------------------------------------------------------------
module bhfd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  bhfd_pkg::t_in_beat  i_beat,
    input  logic [4:0]          i_bin_code,
    output bhfd_pkg::t_res      o_res
);
    import bhfd_pkg::*;

    t_pstate r_state;
    t_pstate n_state;
    t_pstate s_bits [0:8];
    t_pstate s_after;
    t_pstate s_fin;

    // Eight header bits, most significant first. Only the last bit of a byte
    // lands on a byte boundary.
    always_comb begin
        s_bits[0] = r_state;
        for (int i = 0; i < 8; i++) begin
            s_bits[i+1] = bit_step(s_bits[i], i_beat.frame_byte[7-i], i_bin_code, i == 7);
        end
    end

    always_comb begin
        s_after = r_state;
        o_res   = '0;
        if (r_state.phase == PH_META || r_state.phase == PH_PAYLOAD) begin
            o_res.data_valid              = 1'b1;
            o_res.data_beat.item_kind     = (r_state.phase == PH_META) ? KIND_META
                                                                       : KIND_PAYLOAD;
            o_res.data_beat.data_out      = i_beat.frame_byte;
            if (r_state.phase == PH_META) begin
                s_after.meta_rem = r_state.meta_rem - 8'd1;
                if (s_after.meta_rem == 8'd0) begin
                    s_after = after_meta(s_after, i_bin_code, 1'b1);
                end
            end
        end else if (r_state.phase != PH_DISCARD) begin
            s_after = s_bits[8];
        end

        s_fin = finish(s_after, i_bin_code);
        o_res.sum_valid                 = i_beat.frame_end;
        o_res.sum_beat.item_kind        = KIND_SUMMARY;
        o_res.sum_beat.data_out         = 8'd0;
        o_res.sum_beat.versioned_flag   = s_fin.hdr.versioned;
        o_res.sum_beat.version_byte     = s_fin.hdr.version;
        o_res.sum_beat.message_type     = s_fin.hdr.mtype;
        o_res.sum_beat.compressed_flag  = s_fin.hdr.compressed;
        o_res.sum_beat.metadata_length  = s_fin.hdr.mdata_len;
        o_res.sum_beat.binary_subtype   = s_fin.hdr.subtype;
        o_res.sum_beat.status           = s_fin.err;
        o_res.sum_beat.run_last         = 1'b1;

        n_state = i_beat.frame_end ? STATE_CLEAR : s_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_beat.frame_end) |=> (r_state.phase == PH_SEEK && r_state.hbc == 5'd0))
        else $error("parse state not cleared after the final beat of a frame");

    a_meta_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_META) |-> (r_state.meta_rem != 8'd0))
        else $error("metadata phase with no bytes left");

endmodule

[rtl/bhfd_out_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-header frame result queue
// Small register queue that takes up to two result beats per cycle and
// hands out one beat per cycle on a valid/stall channel while not stalled.
// ----------------------------------------------------------------------------
module bhfd_out_queue #(
    parameter int DEPTH = bhfd_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_a,
    input  bhfd_pkg::t_out_beat i_beat_a,
    input  logic                i_push_b,
    input  bhfd_pkg::t_out_beat i_beat_b,
    output logic                o_room2,
    output logic                o_valid,
    output bhfd_pkg::t_out_beat o_beat,
    input  logic                i_stall
);
    import bhfd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

    t_out_beat         r_mem [DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     n_wr;
    logic [AW-1:0]     n_rd;
    logic [CW-1:0]     n_count;
    logic [AW-1:0]     wr_b;
    logic              pop;

    function automatic logic [AW-1:0] inc(logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + AW'(1);
    endfunction

    assign o_valid = (r_count != '0);
    assign o_beat  = r_mem[r_rd];
    assign o_room2 = (r_count <= ROOM_MAX);
    assign pop     = o_valid && !i_stall;

    always_comb begin
        wr_b    = i_push_a ? inc(r_wr) : r_wr;
        n_wr    = i_push_b ? inc(wr_b) : wr_b;
        n_rd    = pop ? inc(r_rd) : r_rd;
        n_count = r_count + CW'(i_push_a) + CW'(i_push_b) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wr] <= i_beat_a;
        end
        if (i_push_b) begin
            r_mem[wr_b] <= i_beat_b;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue count beyond its depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) + 32'(i_push_a) + 32'(i_push_b)) <= (32'(DEPTH) + 32'(pop)))
        else $error("result queue written while full");

endmodule
